@@ design/format_spec_parser_macros.svh @@
// ----------------------------------------------------------------------------
// Format specification parser assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef FORMAT_SPEC_PARSER_MACROS_SVH
`define FORMAT_SPEC_PARSER_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define FSP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that a condition in one cycle is followed by an outcome in the next.
`define FSP_ASSERT_NEXT(label, cond, nxt, msg) \
   `FSP_ASSERT(label, (cond) |=> (nxt), msg)

`endif

@@ design/fsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format specification parser package
// Character codes, result codes, the result record and small helpers.
// ----------------------------------------------------------------------------
package fsp_pkg;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_BRACE = 2'd1,
      ST_UNKNOWN  = 2'd2,
      ST_NO_PREC  = 2'd3
   } status_type;

   localparam logic [2:0] ALIGN_NONE   = 3'd0;
   localparam logic [2:0] ALIGN_LEFT   = 3'd1;
   localparam logic [2:0] ALIGN_RIGHT  = 3'd2;
   localparam logic [2:0] ALIGN_PAD    = 3'd3;
   localparam logic [2:0] ALIGN_CENTER = 3'd4;

   localparam logic [1:0] SIGN_PLUS  = 2'd1;
   localparam logic [1:0] SIGN_MINUS = 2'd2;
   localparam logic [1:0] SIGN_SPACE = 2'd3;

   localparam logic [1:0] GROUP_UNDER  = 2'd1;
   localparam logic [1:0] GROUP_COMMA  = 2'd2;
   localparam logic [1:0] GROUP_LOCALE = 2'd3;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LBRACE = "{";
   localparam logic [7:0] CH_RBRACE = "}";
   localparam logic [7:0] CH_PLUS   = "+";
   localparam logic [7:0] CH_MINUS  = "-";
   localparam logic [7:0] CH_SPACE  = " ";
   localparam logic [7:0] CH_HASH   = "#";
   localparam logic [7:0] CH_ZERO   = "0";
   localparam logic [7:0] CH_NINE   = "9";
   localparam logic [7:0] CH_UNDER  = "_";
   localparam logic [7:0] CH_COMMA  = ",";
   localparam logic [7:0] CH_LOCALE = "L";
   localparam logic [7:0] CH_DOT    = ".";
   localparam logic [7:0] CH_LT     = "<";
   localparam logic [7:0] CH_GT     = ">";
   localparam logic [7:0] CH_EQ     = "=";
   localparam logic [7:0] CH_CARET  = "^";

   typedef struct packed {
      status_type  status;
      logic [7:0]  fill_char;
      logic [2:0]  align_code;
      logic [1:0]  sign_code;
      logic        alt_form;
      logic [7:0]  width_code;
      logic [7:0]  precision_code;
      logic [1:0]  grouping_code;
      logic [7:0]  type_char;
      logic [7:0]  spec_length;
   } result_type;

   function automatic logic [2:0] align_of(input logic [7:0] c);
      logic [2:0] a;
      case (c)
         CH_LT:    a = ALIGN_LEFT;
         CH_GT:    a = ALIGN_RIGHT;
         CH_EQ:    a = ALIGN_PAD;
         CH_CARET: a = ALIGN_CENTER;
         default:  a = ALIGN_NONE;
      endcase
      return a;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_type(input logic [7:0] c);
      logic t;
      case (c)
         "c", "s", "d", "u", "e", "E", "f", "F", "a", "A",
         "g", "G", "b", "B", "o", "O", "x", "X", "n", "p": t = 1'b1;
         default: t = 1'b0;
      endcase
      return t;
   endfunction

   function automatic logic [7:0] count_inc(input logic [7:0] n);
      return (n == 8'hFF) ? n : n + 8'd1;
   endfunction

endpackage

@@ design/fsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format specification parser channels
// Character request channel and parse result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       start_req;

   modport source (output valid, ch, start_req, input ready);
   modport sink (input valid, ch, start_req, output ready);
endinterface

interface fsp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] fill_char;
   logic [2:0] align_code;
   logic [1:0] sign_code;
   logic       alt_form;
   logic [7:0] width_code;
   logic [7:0] precision_code;
   logic [1:0] grouping_code;
   logic [7:0] type_char;
   logic [7:0] spec_length;

   modport source (output valid, status, fill_char, align_code, sign_code, alt_form,
                   width_code, precision_code, grouping_code, type_char, spec_length,
                   input ready);
   modport sink (input valid, status, fill_char, align_code, sign_code, alt_form,
                 width_code, precision_code, grouping_code, type_char, spec_length,
                 output ready);
endinterface

@@ design/format_spec_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format specification parser
// Parses [[fill]align][sign][#][0][width][grouping][.precision][type] from a
// character stream and returns one record per specification.
// ----------------------------------------------------------------------------
// Channel    Direction  Payload
// req_chan   in         ch, start_req (one character per transfer)
// rsp_chan   out        status and parsed record, one per specification
//
// One character is taken per clock cycle unless the result register is stalled;
// the parse step sits between the parse state and the result register, so a
// result appears in the cycle after the character that ends the specification.
// Reset clears the parse state and the result valid flag.
// A character is taken whenever the result register is empty or its result
// is being transferred in the same cycle.
// ----------------------------------------------------------------------------
module format_spec_parser import fsp_pkg::*; #(
   parameter int unsigned LIMIT_MAX = 254
) (
   input  logic      clock,
   input  logic      reset,
   fsp_req_if.sink   req_chan,
   fsp_rsp_if.source rsp_chan
);

   logic       req_fire;
   logic       rsp_fire;
   logic       rsp_valid;
   result_type rsp_result;

   assign req_chan.ready = !rsp_valid || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_valid && rsp_chan.ready;

   fsp_core #(
      .LIMIT_MAX (LIMIT_MAX)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .in_fire    (req_fire),
      .in_ch      (req_chan.ch),
      .in_start   (req_chan.start_req),
      .out_fire   (rsp_fire),
      .out_valid  (rsp_valid),
      .out_result (rsp_result)
   );

   assign rsp_chan.valid          = rsp_valid;
   assign rsp_chan.status         = rsp_result.status;
   assign rsp_chan.fill_char      = rsp_result.fill_char;
   assign rsp_chan.align_code     = rsp_result.align_code;
   assign rsp_chan.sign_code      = rsp_result.sign_code;
   assign rsp_chan.alt_form       = rsp_result.alt_form;
   assign rsp_chan.width_code     = rsp_result.width_code;
   assign rsp_chan.precision_code = rsp_result.precision_code;
   assign rsp_chan.grouping_code  = rsp_result.grouping_code;
   assign rsp_chan.type_char      = rsp_result.type_char;
   assign rsp_chan.spec_length    = rsp_result.spec_length;

endmodule

@@ design/fsp_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format specification parser core
// Parse state, one character per transfer, and the result register.
// ----------------------------------------------------------------------------
module fsp_core import fsp_pkg::*; #(
   parameter int unsigned LIMIT_MAX = 254
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_fire,
   input  logic [7:0] in_ch,
   input  logic       in_start,
   input  logic       out_fire,
   output logic       out_valid,
   output result_type out_result
);

   localparam logic [11:0] LIMIT = 12'(LIMIT_MAX);

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_HOLD  = 3'd1,
      PH_BODY  = 3'd2,
      PH_WIDTH = 3'd3,
      PH_DOT   = 3'd4,
      PH_PREC  = 3'd5
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] fill;
      logic [2:0] align;
      logic [1:0] sign;
      logic       hash;
      logic [7:0] width;
      logic [7:0] prec;
      logic [1:0] grouping;
      logic [7:0] type_ch;
      logic [7:0] accum;
      logic [7:0] count;
   } parse_type;

   typedef struct packed {
      parse_type  st;
      logic       done;
      status_type status;
   } step_type;

   function automatic logic [7:0] sat_next(input logic [7:0] acc, input logic [7:0] c);
      logic [11:0] v;
      v = 12'(acc) * 12'd10 + 12'(c - CH_ZERO);
      if (v > LIMIT) begin
         v = LIMIT;
      end
      return v[7:0];
   endfunction

   function automatic step_type body_byte(input parse_type s, input logic [7:0] c);
      step_type   r;
      logic [7:0] acc;
      r.st     = s;
      r.done   = 1'b0;
      r.status = ST_OK;
      if (s.phase == PH_DOT) begin
         if (!is_digit(c)) begin
            r.done   = 1'b1;
            r.status = ST_NO_PREC;
         end else begin
            acc         = sat_next(8'd0, c);
            r.st.accum  = acc;
            r.st.prec   = acc + 8'd1;
            r.st.phase  = PH_PREC;
            r.st.count  = count_inc(s.count);
         end
      end else if ((s.phase == PH_WIDTH || s.phase == PH_PREC) && is_digit(c)) begin
         acc        = sat_next(s.accum, c);
         r.st.accum = acc;
         if (s.phase == PH_WIDTH) begin
            r.st.width = acc + 8'd1;
         end else begin
            r.st.prec = acc + 8'd1;
         end
         r.st.count = count_inc(s.count);
      end else begin
         r.st.phase = PH_BODY;
         r.st.count = count_inc(s.count);
         case (c)
            CH_RBRACE: begin
               r.done   = 1'b1;
               r.status = ST_OK;
            end
            CH_NUL: begin
               r.done   = 1'b1;
               r.status = ST_NO_BRACE;
            end
            CH_PLUS:   r.st.sign = SIGN_PLUS;
            CH_MINUS:  r.st.sign = SIGN_MINUS;
            CH_SPACE:  r.st.sign = SIGN_SPACE;
            CH_HASH:   r.st.hash = 1'b1;
            CH_ZERO: begin
               if (s.align == ALIGN_NONE) begin
                  r.st.fill  = CH_ZERO;
                  r.st.align = ALIGN_PAD;
               end
            end
            CH_UNDER:  r.st.grouping = GROUP_UNDER;
            CH_COMMA:  r.st.grouping = GROUP_COMMA;
            CH_LOCALE: r.st.grouping = GROUP_LOCALE;
            CH_DOT:    r.st.phase = PH_DOT;
            default: begin
               if (is_digit(c)) begin
                  acc        = sat_next(8'd0, c);
                  r.st.accum = acc;
                  r.st.width = acc + 8'd1;
                  r.st.phase = PH_WIDTH;
               end else if (is_type(c)) begin
                  r.st.type_ch = c;
               end else begin
                  r.done   = 1'b1;
                  r.status = ST_UNKNOWN;
               end
            end
         endcase
      end
      return r;
   endfunction

   parse_type  parse_ff, parse_in;
   logic [7:0] held_ff, held_in;
   logic       out_valid_ff, out_valid_in;
   result_type result_ff, result_in;

   step_type   first_step, final_step;
   parse_type  base;

   always_comb begin
      base       = parse_ff;
      held_in    = held_ff;
      first_step = '0;
      final_step = '0;
      if (in_start) begin
         base = '0;
         if (in_ch == CH_NUL || in_ch == CH_LBRACE || in_ch == CH_RBRACE) begin
            base.phase = PH_BODY;
            final_step = body_byte(base, in_ch);
         end else begin
            held_in          = in_ch;
            base.phase       = PH_HOLD;
            final_step.st    = base;
         end
      end else if (parse_ff.phase == PH_IDLE) begin
         final_step.st = parse_ff;
      end else if (parse_ff.phase == PH_HOLD) begin
         base.phase = PH_BODY;
         if (align_of(in_ch) != ALIGN_NONE) begin
            base.fill     = held_ff;
            base.align    = align_of(in_ch);
            base.count    = count_inc(count_inc(base.count));
            final_step.st = base;
         end else begin
            if (align_of(held_ff) != ALIGN_NONE) begin
               base.align    = align_of(held_ff);
               base.count    = count_inc(base.count);
               first_step.st = base;
            end else begin
               first_step = body_byte(base, held_ff);
            end
            if (first_step.done) begin
               final_step = first_step;
            end else begin
               final_step = body_byte(first_step.st, in_ch);
            end
         end
      end else begin
         final_step = body_byte(parse_ff, in_ch);
      end

      parse_in = final_step.st;
      if (final_step.done) begin
         parse_in.phase = PH_IDLE;
      end

      result_in.status         = final_step.status;
      result_in.fill_char      = final_step.st.fill;
      result_in.align_code     = final_step.st.align;
      result_in.sign_code      = final_step.st.sign;
      result_in.alt_form       = final_step.st.hash;
      result_in.width_code     = final_step.st.width;
      result_in.precision_code = final_step.st.prec;
      result_in.grouping_code  = final_step.st.grouping;
      result_in.type_char      = final_step.st.type_ch;
      result_in.spec_length    = final_step.st.count;

      if (in_fire) begin
         out_valid_in = final_step.done;
      end else if (out_fire) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (in_fire) begin
            parse_ff <= parse_in;
         end
      end
      if (in_fire) begin
         held_ff <= held_in;
      end
      if (in_fire && final_step.done) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

endmodule

@@ design/fsp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format specification parser checker
// Port-level checks on the request and result channels over time.
// ----------------------------------------------------------------------------
`include "format_spec_parser_macros.svh"

module fsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_spec_length
);

   `FSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_spec_length), "result changed while stalled")
   `FSP_ASSERT(a_rsp_cause, (rsp_valid && !$past(rsp_valid && !rsp_ready)) |-> $past(req_valid && req_ready), "result without a request transfer")
   `FSP_ASSERT(a_req_free, !rsp_valid |-> req_ready, "request stalled with an empty result register")
   `FSP_ASSERT(a_len_nonzero, rsp_valid |-> (rsp_spec_length != 8'd0), "result with zero length")

endmodule

bind format_spec_parser fsp_checker u_fsp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_spec_length (rsp_chan.spec_length)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format specification parser testbench
// Feeds format specifications one character per transfer, first from a short
// table and then as random specifications mixed with noise. Each result record
// is compared field by field with a predictor of the parser kept in step with
// every accepted character. Both channels idle and stall in several phases.
// ----------------------------------------------------------------------------
module testbench;
   import fsp_pkg::*;

   localparam int NUMBER_CAP = 254;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD = 60;
   localparam int ITEM_COUNT = 650;

   typedef enum logic [2:0] {
      PARSE_IDLE,
      PARSE_HOLD,
      PARSE_BODY,
      PARSE_WIDTH,
      PARSE_DOT,
      PARSE_PREC
   } parse_phase_type;

   typedef struct {
      logic [7:0] ch;
      bit         start;
      bit         known;
      result_type record;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   fsp_req_if req_chan();
   fsp_rsp_if rsp_chan();

   format_spec_parser #(.LIMIT_MAX(NUMBER_CAP)) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   parse_phase_type parse_phase;
   logic [7:0]   held_char;
   logic [7:0]   fill_q;
   logic [2:0]   align_q;
   logic [1:0]   sign_q;
   logic         alt_q;
   logic [7:0]   width_q;
   logic [7:0]   prec_q;
   logic [1:0]   group_q;
   logic [7:0]   type_q;
   logic [7:0]   number_q;
   logic [7:0]   length_q;

   string        type_letters = "csdueEfFaAgGbBoOxXnp";
   result_type   expected_records[$];
   stim_row_type stim_rows[$];
   int         error_count = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         quiet_cycles = 0;
   int         counted_items = 0;
   bit         hold_request = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [2:0] align_code_for(input logic [7:0] c);
      case (c)
         CH_LT:    return ALIGN_LEFT;
         CH_GT:    return ALIGN_RIGHT;
         CH_EQ:    return ALIGN_PAD;
         CH_CARET: return ALIGN_CENTER;
         default:  return ALIGN_NONE;
      endcase
   endfunction

   function automatic bit conversion_letter(input logic [7:0] c);
      for (int i = 0; i < type_letters.len(); i++) begin
         if (type_letters[i] == c) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void clear_spec();
      held_char = 8'd0;
      fill_q = 8'd0;
      align_q = ALIGN_NONE;
      sign_q = 2'd0;
      alt_q = 1'b0;
      width_q = 8'd0;
      prec_q = 8'd0;
      group_q = 2'd0;
      type_q = 8'd0;
      number_q = 8'd0;
      length_q = 8'd0;
   endfunction

   function automatic void bump_length();
      if (length_q != 8'hFF) length_q++;
   endfunction

   function automatic logic [7:0] fold_digit(input logic [7:0] c);
      int v;
      v = number_q * 10 + (c - CH_ZERO);
      if (v > NUMBER_CAP) v = NUMBER_CAP;
      number_q = v[7:0];
      return number_q + 8'd1;
   endfunction

   function automatic bit take_body(input logic [7:0] c, output status_type st);
      bit digit;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      st = ST_OK;
      if (parse_phase == PARSE_DOT) begin
         if (!digit) begin
            st = ST_NO_PREC;
            return 1'b1;
         end
         number_q = 8'd0;
         prec_q = fold_digit(c);
         parse_phase = PARSE_PREC;
         bump_length();
         return 1'b0;
      end
      if (digit && parse_phase == PARSE_WIDTH) begin
         width_q = fold_digit(c);
         bump_length();
         return 1'b0;
      end
      if (digit && parse_phase == PARSE_PREC) begin
         prec_q = fold_digit(c);
         bump_length();
         return 1'b0;
      end
      parse_phase = PARSE_BODY;
      bump_length();
      case (c)
         CH_RBRACE: return 1'b1;
         CH_NUL: begin
            st = ST_NO_BRACE;
            return 1'b1;
         end
         CH_PLUS:   sign_q = SIGN_PLUS;
         CH_MINUS:  sign_q = SIGN_MINUS;
         CH_SPACE:  sign_q = SIGN_SPACE;
         CH_HASH:   alt_q = 1'b1;
         CH_ZERO: begin
            if (align_q == ALIGN_NONE) begin
               fill_q = CH_ZERO;
               align_q = ALIGN_PAD;
            end
         end
         CH_UNDER:  group_q = GROUP_UNDER;
         CH_COMMA:  group_q = GROUP_COMMA;
         CH_LOCALE: group_q = GROUP_LOCALE;
         CH_DOT:    parse_phase = PARSE_DOT;
         default: begin
            if (digit) begin
               number_q = 8'd0;
               width_q = fold_digit(c);
               parse_phase = PARSE_WIDTH;
            end else if (conversion_letter(c)) begin
               type_q = c;
            end else begin
               st = ST_UNKNOWN;
               return 1'b1;
            end
         end
      endcase
      return 1'b0;
   endfunction

   function automatic bit predict_char(input logic [7:0] c, input bit start,
                                       output result_type rec);
      status_type st;
      bit ended;
      ended = 1'b0;
      st = ST_OK;
      rec = '0;
      if (start) begin
         clear_spec();
         if (c == CH_NUL || c == CH_LBRACE || c == CH_RBRACE) begin
            parse_phase = PARSE_BODY;
            ended = take_body(c, st);
         end else begin
            held_char = c;
            parse_phase = PARSE_HOLD;
         end
      end else if (parse_phase == PARSE_IDLE) begin
         return 1'b0;
      end else if (parse_phase == PARSE_HOLD) begin
         parse_phase = PARSE_BODY;
         if (align_code_for(c) != ALIGN_NONE) begin
            fill_q = held_char;
            align_q = align_code_for(c);
            bump_length();
            bump_length();
         end else begin
            if (align_code_for(held_char) != ALIGN_NONE) begin
               align_q = align_code_for(held_char);
               bump_length();
            end else begin
               ended = take_body(held_char, st);
            end
            if (!ended) ended = take_body(c, st);
         end
      end else begin
         ended = take_body(c, st);
      end
      if (ended) begin
         parse_phase = PARSE_IDLE;
         rec.status = st;
         rec.fill_char = fill_q;
         rec.align_code = align_q;
         rec.sign_code = sign_q;
         rec.alt_form = alt_q;
         rec.width_code = width_q;
         rec.precision_code = prec_q;
         rec.grouping_code = group_q;
         rec.type_char = type_q;
         rec.spec_length = length_q;
      end
      return ended;
   endfunction

   function automatic void add_row(input logic [7:0] c, input bit start);
      stim_row_type r;
      r.ch = c;
      r.start = start;
      r.known = 1'b0;
      r.record = '0;
      stim_rows.push_back(r);
   endfunction

   function automatic void add_known(input logic [7:0] c, input bit start,
                                     input status_type st, input logic [7:0] len);
      stim_row_type r;
      r.ch = c;
      r.start = start;
      r.known = 1'b1;
      r.record = '0;
      r.record.status = st;
      r.record.spec_length = len;
      stim_rows.push_back(r);
   endfunction

   function automatic logic [7:0] random_align();
      case ($urandom_range(3))
         0:       return CH_LT;
         1:       return CH_GT;
         2:       return CH_EQ;
         default: return CH_CARET;
      endcase
   endfunction

   function automatic void add_digits(input int n);
      for (int i = 0; i < n; i++) add_row(8'(CH_ZERO + $urandom_range(9)), 1'b0);
   endfunction

   function automatic void build_spec();
      logic [7:0] c;
      case ($urandom_range(3))
         0: begin
            add_row(8'($urandom_range(255)), 1'b1);
            add_row(random_align(), 1'b0);
         end
         1: add_row(random_align(), 1'b1);
         default: ;
      endcase
      if ($urandom_range(2) == 0) begin
         case ($urandom_range(2))
            0:       add_row(CH_PLUS, stim_rows.size() == 0);
            1:       add_row(CH_MINUS, stim_rows.size() == 0);
            default: add_row(CH_SPACE, stim_rows.size() == 0);
         endcase
      end
      if ($urandom_range(3) == 0) add_row(CH_HASH, stim_rows.size() == 0);
      if ($urandom_range(3) == 0) add_row(CH_ZERO, stim_rows.size() == 0);
      if ($urandom_range(1) == 0) begin
         add_row(8'(CH_ZERO + $urandom_range(9, 1)), stim_rows.size() == 0);
         add_digits(($urandom_range(9) == 0) ? 3 : int'($urandom_range(2)));
      end
      if ($urandom_range(2) == 0) begin
         case ($urandom_range(2))
            0:       add_row(CH_UNDER, stim_rows.size() == 0);
            1:       add_row(CH_COMMA, stim_rows.size() == 0);
            default: add_row(CH_LOCALE, stim_rows.size() == 0);
         endcase
      end
      if ($urandom_range(2) == 0) begin
         add_row(CH_DOT, stim_rows.size() == 0);
         add_digits(int'($urandom_range(3, 1)));
      end
      if ($urandom_range(1) == 0) begin
         add_row(type_letters[$urandom_range(19)], stim_rows.size() == 0);
      end
      case ($urandom_range(19))
         0: add_row(CH_NUL, stim_rows.size() == 0);
         1: add_row(8'($urandom_range(255)), stim_rows.size() == 0);
         2: begin
            add_row(CH_DOT, stim_rows.size() == 0);
            c = 8'($urandom_range(255));
            while (c >= CH_ZERO && c <= CH_NINE) c = 8'($urandom_range(255));
            add_row(c, 1'b0);
         end
         default: add_row(CH_RBRACE, stim_rows.size() == 0);
      endcase
   endfunction

   function automatic void build_noise();
      int n;
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) begin
         add_row(8'($urandom_range(255)), $urandom_range(3) == 0);
      end
   endfunction

   function automatic void set_idling(input int spec_no);
      case ((spec_no / 10) % 4)
         0: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct = 67;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            recv_stall_pct = 67;
         end
         default: begin
            send_idle_pct = 28;
            recv_stall_pct = 28;
         end
      endcase
   endfunction

   task automatic offer(input stim_row_type r);
      result_type rec;
      bit produced;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.ch <= r.ch;
      req_chan.start_req <= r.start;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      counted_items++;
      produced = predict_char(r.ch, r.start, rec);
      if (r.known) expected_records.push_back(r.record);
      else if (produced) expected_records.push_back(rec);
   endtask

   task automatic send_rows();
      foreach (stim_rows[i]) offer(stim_rows[i]);
      stim_rows.delete();
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   task automatic check_record();
      result_type want;
      if (expected_records.size() == 0) begin
         $error("result transfer with no record expected");
         error_count++;
      end else begin
         want = expected_records.pop_front();
         compare_field("status", 32'(want.status), 32'(rsp_chan.status));
         compare_field("fill_char", 32'(want.fill_char), 32'(rsp_chan.fill_char));
         compare_field("align_code", 32'(want.align_code), 32'(rsp_chan.align_code));
         compare_field("sign_code", 32'(want.sign_code), 32'(rsp_chan.sign_code));
         compare_field("alt_form", 32'(want.alt_form), 32'(rsp_chan.alt_form));
         compare_field("width_code", 32'(want.width_code), 32'(rsp_chan.width_code));
         compare_field("precision_code", 32'(want.precision_code),
                       32'(rsp_chan.precision_code));
         compare_field("grouping_code", 32'(want.grouping_code),
                       32'(rsp_chan.grouping_code));
         compare_field("type_char", 32'(want.type_char), 32'(rsp_chan.type_char));
         compare_field("spec_length", 32'(want.spec_length), 32'(rsp_chan.spec_length));
      end
   endtask

   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
         @(posedge clock);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) check_record();
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      int spec_no;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.ch <= 8'd0;
      req_chan.start_req <= 1'b0;
      parse_phase = PARSE_IDLE;
      clear_spec();

      add_known(CH_RBRACE, 1'b1, ST_OK, 8'd1);
      add_known(CH_NUL, 1'b1, ST_NO_BRACE, 8'd1);
      add_known(CH_LBRACE, 1'b1, ST_UNKNOWN, 8'd1);
      add_row("*", 1'b1);
      add_row(CH_CARET, 1'b0);
      add_row(CH_MINUS, 1'b0);
      add_row(CH_HASH, 1'b0);
      add_row("9", 1'b0);
      add_row("9", 1'b0);
      add_row(CH_UNDER, 1'b0);
      add_row(CH_DOT, 1'b0);
      add_row("5", 1'b0);
      add_row("x", 1'b0);
      add_row(CH_RBRACE, 1'b0);
      add_row(CH_ZERO, 1'b1);
      add_row(CH_LOCALE, 1'b0);
      add_row(CH_DOT, 1'b0);
      add_row("Z", 1'b0);
      add_row(CH_GT, 1'b1);
      add_row(CH_PLUS, 1'b0);
      add_row(CH_RBRACE, 1'b0);
      add_row(8'hFF, 1'b1);
      add_known(CH_RBRACE, 1'b0, ST_UNKNOWN, 8'd1);
      add_row("x", 1'b0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      send_rows();

      // A long width pushes both the width and the consumed length to saturation.
      add_row(CH_GT, 1'b1);
      for (int i = 0; i < 257; i++) add_row("9", 1'b0);
      add_row(CH_RBRACE, 1'b0);
      send_rows();

      spec_no = 0;
      while (counted_items < ITEM_COUNT) begin
         set_idling(spec_no);
         if (spec_no == 30) begin
            hold_request = 1'b1;
            for (int i = 0; i < 6; i++) add_row(CH_RBRACE, 1'b1);
            send_rows();
            req_chan.valid <= 1'b0;
            while (expected_records.size() != 0) @(posedge clock);
         end
         if ($urandom_range(99) < 80) build_spec();
         else build_noise();
         send_rows();
         spec_no++;
      end
      req_chan.valid <= 1'b0;

      while (expected_records.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+design
design/fsp_pkg.sv
design/fsp_if.sv
design/fsp_core.sv
design/format_spec_parser.sv
design/fsp_checker.sv
verif/testbench.sv
